FILE: src/pas_pkg.sv
`default_nettype none

package pas_pkg;

  // table geometry
  localparam int NUM_TASKS = 16;
  localparam int IDX_W     = $clog2(NUM_TASKS);
  localparam int CNT_W     = $clog2(NUM_TASKS + 1);

  // field widths
  localparam int OP_W    = 3;
  localparam int SLOT_W  = 4;
  localparam int LEVEL_W = 6;
  localparam int STS_W   = 2;
  localparam int QNT_W   = 8;
  localparam int WORD_W  = 2 * LEVEL_W;   // {static, dynamic}

  localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = LEVEL_W'(-20);
  localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(20);

  // opcodes
  localparam logic [OP_W-1:0] OP_ADD      = 3'd0;
  localparam logic [OP_W-1:0] OP_SET_PRIO = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE   = 3'd2;
  localparam logic [OP_W-1:0] OP_SCHEDULE = 3'd3;
  localparam logic [OP_W-1:0] OP_TICK     = 3'd4;
  localparam logic [OP_W-1:0] OP_YIELD    = 3'd5;

  // status codes
  localparam logic [STS_W-1:0] STS_OK       = 2'd0;
  localparam logic [STS_W-1:0] STS_NO_READY = 2'd1;
  localparam logic [STS_W-1:0] STS_BAD_SLOT = 2'd2;

  // config space
  localparam int                APB_ADDR_W  = 3;
  localparam logic              REG_QLEN    = 1'b0;   // word index
  localparam logic [QNT_W-1:0]  QLEN_RESET  = 8'd20;

  function automatic logic signed [LEVEL_W-1:0] sat_level(input logic signed [LEVEL_W-1:0] v);
    logic signed [LEVEL_W-1:0] r;
    r = v;
    if (v < LEVEL_MIN) begin
      r = LEVEL_MIN;
    end else if (v > LEVEL_MAX) begin
      r = LEVEL_MAX;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: src/priority_aging_scheduler_core.sv
// Priority scheduler with aging: a table of task slots, each with a static and
// a dynamic priority (lower value = more urgent), plus the running task's quantum.
//
// Input channel (in_valid/in_stall): one beat carries opcode, slot, priority_req.
// Result channel (out_valid/out_stall): exactly one beat per input beat, in order.
// Config: APB-style, one register, quantum_length at byte address 0.
//
// Add, set priority, remove, tick, yield and unused opcodes go from accept
// straight to the hand-off state. Schedule makes two walks over the level RAM
// (only the first on an empty table): one walk to find the winner, one
// read-modify-write walk to age the others and reload the winner. The level
// RAM has one read port. One item is in flight at a time; in_stall is high
// from accept until the result is loaded into the output reg, so no new beat
// is taken before then.
//
// Reset clears valid bits, the quantum, the running flag and the current slot
// and loads quantum_length with 20. The level RAM is not cleared: an entry is
// only used while its valid bit is set, and add always writes it first.
// If the receiver stalls, the result waits in the output register and the
// block holds the next result back until the output register frees up.

`default_nettype none

module priority_aging_scheduler_core (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input channel
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [pas_pkg::OP_W-1:0]         in_opcode,
  input  wire logic [pas_pkg::SLOT_W-1:0]       in_slot,
  input  wire logic signed [pas_pkg::LEVEL_W-1:0] in_priority_req,
  // result channel
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [pas_pkg::STS_W-1:0]             out_status,
  output logic [pas_pkg::SLOT_W-1:0]            out_chosen_slot,
  output logic                                  out_preempt,
  output logic [pas_pkg::QNT_W-1:0]             out_quantum_left,
  // config port
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [pas_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                      pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);

  import pas_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEL,    // walk 1: find lowest dynamic level
    ST_PICK,   // decide: empty table or go age
    ST_AGE,    // walk 2: read-modify-write every entry
    ST_OUT     // hand result to output register
  } state_t;

  state_t state_r, state_nxt;

  // control / walk state
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      rd_v_r, rd_v_nxt;
  logic [IDX_W-1:0]          rd_idx_r, rd_idx_nxt;
  logic                      found_r, found_nxt;
  logic [IDX_W-1:0]          best_r, best_nxt;
  logic signed [LEVEL_W-1:0] best_lvl_r, best_lvl_nxt;

  // architectural state
  logic [NUM_TASKS-1:0]      valid_r, valid_nxt;
  logic [QNT_W-1:0]          quantum_r, quantum_nxt;
  logic                      running_r, running_nxt;
  logic [SLOT_W-1:0]         cur_slot_r, cur_slot_nxt;
  logic [QNT_W-1:0]          qlen_r, qlen_nxt;

  // per-item result
  logic [STS_W-1:0]          status_r, status_nxt;
  logic                      preempt_r, preempt_nxt;

  // output register
  logic                      out_valid_r, out_valid_nxt;
  logic [STS_W-1:0]          out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]         out_slot_r, out_slot_nxt;
  logic                      out_preempt_r, out_preempt_nxt;
  logic [QNT_W-1:0]          out_quantum_r, out_quantum_nxt;

  // level RAM
  logic                      ram_we;
  logic [IDX_W-1:0]          ram_waddr;
  logic [WORD_W-1:0]         ram_wdata;
  logic [WORD_W-1:0]         ram_rdata;
  logic signed [LEVEL_W-1:0] rd_stat, rd_dyn;

  logic                      in_acc;
  logic                      in_table;
  logic [IDX_W-1:0]          in_idx;
  logic signed [LEVEL_W-1:0] pr_sat;
  logic                      out_free;
  logic                      cfg_wr;

  pas_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_TASKS)
  ) u_level_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_stat = ram_rdata[WORD_W-1:LEVEL_W];
  assign rd_dyn  = ram_rdata[LEVEL_W-1:0];

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign in_table = (int'(in_slot) < NUM_TASKS);
  assign in_idx   = IDX_W'(in_slot);
  assign pr_sat   = sat_level(in_priority_req);
  assign out_free = !out_valid_r || !out_stall;

  // config
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[APB_ADDR_W-1:2] == REG_QLEN);
  assign prdata = (paddr[APB_ADDR_W-1:2] == REG_QLEN) ? {24'd0, qlen_r} : 32'd0;

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    rd_v_nxt        = 1'b0;
    rd_idx_nxt      = rd_idx_r;
    found_nxt       = found_r;
    best_nxt        = best_r;
    best_lvl_nxt    = best_lvl_r;
    valid_nxt       = valid_r;
    quantum_nxt     = quantum_r;
    running_nxt     = running_r;
    cur_slot_nxt    = cur_slot_r;
    qlen_nxt        = cfg_wr ? pwdata[QNT_W-1:0] : qlen_r;
    status_nxt      = status_r;
    preempt_nxt     = preempt_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_status_nxt  = out_status_r;
    out_slot_nxt    = out_slot_r;
    out_preempt_nxt = out_preempt_r;
    out_quantum_nxt = out_quantum_r;
    ram_we          = 1'b0;
    ram_waddr       = in_idx;
    ram_wdata       = {pr_sat, pr_sat};

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          status_nxt  = STS_OK;
          preempt_nxt = 1'b0;
          state_nxt   = ST_OUT;
          case (in_opcode)
            OP_ADD: begin
              if (!in_table || valid_r[in_idx]) begin
                status_nxt = STS_BAD_SLOT;
              end else begin
                valid_nxt[in_idx] = 1'b1;
                ram_we            = 1'b1;
              end
            end
            OP_SET_PRIO: begin
              if (!in_table || !valid_r[in_idx]) begin
                status_nxt = STS_BAD_SLOT;
              end else begin
                ram_we = 1'b1;
              end
            end
            OP_REMOVE: begin
              if (!in_table || !valid_r[in_idx]) begin
                status_nxt = STS_BAD_SLOT;
              end else begin
                valid_nxt[in_idx] = 1'b0;
                if (running_r && (cur_slot_r == in_slot)) begin
                  running_nxt = 1'b0;
                  quantum_nxt = '0;
                end
              end
            end
            OP_SCHEDULE: begin
              cnt_nxt   = '0;
              found_nxt = 1'b0;
              state_nxt = ST_SEL;
            end
            OP_TICK: begin
              if (running_r) begin
                if (quantum_r != '0) begin
                  quantum_nxt = quantum_r - 1'b1;
                end else begin
                  preempt_nxt = 1'b1;
                  running_nxt = 1'b0;
                end
              end
            end
            OP_YIELD: begin
              running_nxt = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end

      ST_SEL: begin
        // data for rd_idx_r arrives in the cycle after its address
        if (rd_v_r && valid_r[rd_idx_r] && (!found_r || (rd_dyn < best_lvl_r))) begin
          found_nxt    = 1'b1;
          best_nxt     = rd_idx_r;
          best_lvl_nxt = rd_dyn;
        end
        if (cnt_r < CNT_W'(NUM_TASKS)) begin
          rd_v_nxt   = 1'b1;
          rd_idx_nxt = cnt_r[IDX_W-1:0];
          cnt_nxt    = cnt_r + 1'b1;
        end else begin
          state_nxt = ST_PICK;
        end
      end

      ST_PICK: begin
        if (!found_r) begin
          status_nxt  = STS_NO_READY;
          running_nxt = 1'b0;
          state_nxt   = ST_OUT;
        end else begin
          cnt_nxt   = '0;
          state_nxt = ST_AGE;
        end
      end

      ST_AGE: begin
        // write-back of entry i lands in the cycle entry i+1 is read: no overlap
        if (rd_v_r) begin
          ram_waddr = rd_idx_r;
          if (rd_idx_r == best_r) begin
            ram_we    = 1'b1;
            ram_wdata = {rd_stat, rd_stat};
          end else if (valid_r[rd_idx_r] && (rd_dyn > LEVEL_MIN)) begin
            ram_we    = 1'b1;
            ram_wdata = {rd_stat, rd_dyn - LEVEL_W'(1)};
          end
        end
        if (cnt_r < CNT_W'(NUM_TASKS)) begin
          rd_v_nxt   = 1'b1;
          rd_idx_nxt = cnt_r[IDX_W-1:0];
          cnt_nxt    = cnt_r + 1'b1;
        end else begin
          quantum_nxt  = qlen_r;
          cur_slot_nxt = SLOT_W'(best_r);
          running_nxt  = 1'b1;
          status_nxt   = STS_OK;
          state_nxt    = ST_OUT;
        end
      end

      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = status_r;
          out_slot_nxt    = cur_slot_r;
          out_preempt_nxt = preempt_r;
          out_quantum_nxt = quantum_r;
          state_nxt       = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      rd_v_r      <= 1'b0;
      found_r     <= 1'b0;
      valid_r     <= '0;
      quantum_r   <= '0;
      running_r   <= 1'b0;
      cur_slot_r  <= '0;
      qlen_r      <= QLEN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_v_r      <= rd_v_nxt;
      found_r     <= found_nxt;
      valid_r     <= valid_nxt;
      quantum_r   <= quantum_nxt;
      running_r   <= running_nxt;
      cur_slot_r  <= cur_slot_nxt;
      qlen_r      <= qlen_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rd_idx_r      <= rd_idx_nxt;
    best_r        <= best_nxt;
    best_lvl_r    <= best_lvl_nxt;
    status_r      <= status_nxt;
    preempt_r     <= preempt_nxt;
    out_status_r  <= out_status_nxt;
    out_slot_r    <= out_slot_nxt;
    out_preempt_r <= out_preempt_nxt;
    out_quantum_r <= out_quantum_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_chosen_slot  = out_slot_r;
  assign out_preempt      = out_preempt_r;
  assign out_quantum_left = out_quantum_r;

  // a running task always sits in a valid slot
  a_running_valid: assert property (@(posedge clk) disable iff (!rst_n)
    running_r |-> valid_r[IDX_W'(cur_slot_r)])
    else $error("running task in empty slot");

  // walk counter never runs past the table
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(NUM_TASKS))
    else $error("walk counter out of range");

  // the aging walk only runs with a winner that is still valid
  a_age_best: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_AGE) |-> (found_r && valid_r[best_r]))
    else $error("aging without valid winner");

  // a new result beat only comes out of the hand-off state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r && out_stall)) |-> $past(state_r == ST_OUT))
    else $error("result beat without hand-off");

  // an item is taken only while idle, and idle follows only the hand-off
  a_idle_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && out_free) |=> (state_r == ST_IDLE && out_valid_r))
    else $error("hand-off did not complete");

endmodule

`default_nettype wire

FILE: src/pas_ram.sv
`default_nettype none

module pas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pas_pkg::*;

  // opcodes the block must ignore
  localparam logic [OP_W-1:0] OP_RSVD_A = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_B = 3'd7;

  // saturation bounds for stored priorities
  localparam int LVL_FLOOR = -20;
  localparam int LVL_CEIL  = 20;

  // byte address of the quantum length register
  localparam logic [APB_ADDR_W-1:0] QLEN_ADDR = APB_ADDR_W'(4 * REG_QLEN);

  // settle time after the last result: a schedule walks the table twice
  localparam int SETTLE_CYCLES = 2 * NUM_TASKS + 8;

  // one result beat as the scheduler should report it; op is kept for messages
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [STS_W-1:0]  status;
    logic [SLOT_W-1:0] chosen;
    logic              preempt;
    logic [QNT_W-1:0]  qleft;
  } sched_result_t;

  // ---------------------------------------------------------------------------
  // clock, reset and block I/O; every input has a known value from time 0
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [OP_W-1:0]           in_opcode = OP_YIELD;
  logic [SLOT_W-1:0]         in_slot = '0;
  logic signed [LEVEL_W-1:0] in_priority_req = '0;

  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [STS_W-1:0]          out_status;
  logic [SLOT_W-1:0]         out_chosen_slot;
  logic                      out_preempt;
  logic [QNT_W-1:0]          out_quantum_left;

  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]     paddr = '0;
  logic [31:0]               pwdata = '0;
  logic [31:0]               prdata;
  logic                      pready;

  priority_aging_scheduler_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_slot          (in_slot),
    .in_priority_req  (in_priority_req),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_chosen_slot  (out_chosen_slot),
    .out_preempt      (out_preempt),
    .out_quantum_left (out_quantum_left),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop in case a handshake never completes
  initial begin
    #10ms;
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // scheduler shadow: its own copy of the table, the quantum and the register
  // ---------------------------------------------------------------------------
  bit                        slot_used [NUM_TASKS];
  logic signed [LEVEL_W-1:0] base_prio [NUM_TASKS];
  logic signed [LEVEL_W-1:0] live_prio [NUM_TASKS];
  logic [QNT_W-1:0]          ticks_left = '0;
  logic [QNT_W-1:0]          grant_len = QLEN_RESET;
  bit                        task_running = 1'b0;
  logic [SLOT_W-1:0]         running_slot = '0;

  sched_result_t expected_results[$];
  sched_result_t oldest;
  int            fail_count = 0;

  // idle rates in percent, set per phase
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // request priorities are clamped into the legal band before they are stored
  function automatic logic signed [LEVEL_W-1:0] clamp_level(input logic [LEVEL_W-1:0] raw);
    int v;
    v = int'($signed(raw));
    if (v < LVL_FLOOR) v = LVL_FLOOR;
    if (v > LVL_CEIL)  v = LVL_CEIL;
    return LEVEL_W'(v);
  endfunction

  // applies one command to the shadow table and returns the beat it must produce
  function automatic sched_result_t predict_sched_step(input logic [OP_W-1:0] op,
                                                       input logic [SLOT_W-1:0] slot,
                                                       input logic [LEVEL_W-1:0] raw_prio);
    sched_result_t r;
    logic signed [LEVEL_W-1:0] lvl;
    int best;
    int i;
    lvl = clamp_level(raw_prio);
    r.op = op;
    r.status = STS_OK;
    r.preempt = 1'b0;
    case (op)
      OP_ADD: begin
        if (slot_used[slot]) begin
          r.status = STS_BAD_SLOT;
        end else begin
          slot_used[slot] = 1'b1;
          base_prio[slot] = lvl;
          live_prio[slot] = lvl;
        end
      end
      OP_SET_PRIO: begin
        if (!slot_used[slot]) begin
          r.status = STS_BAD_SLOT;
        end else begin
          base_prio[slot] = lvl;
          live_prio[slot] = lvl;
        end
      end
      OP_REMOVE: begin
        if (!slot_used[slot]) begin
          r.status = STS_BAD_SLOT;
        end else begin
          slot_used[slot] = 1'b0;
          // pulling the running task also drops its quantum
          if (task_running && running_slot == slot) begin
            task_running = 1'b0;
            ticks_left = '0;
          end
        end
      end
      OP_SCHEDULE: begin
        // strict less-than keeps the lowest index on a tie
        best = -1;
        for (i = 0; i < NUM_TASKS; i++) begin
          if (slot_used[i] && (best < 0 || live_prio[i] < live_prio[best])) best = i;
        end
        if (best < 0) begin
          r.status = STS_NO_READY;
          task_running = 1'b0;
        end else begin
          // everyone else ages toward the floor
          for (i = 0; i < NUM_TASKS; i++) begin
            if (slot_used[i] && i != best && int'(live_prio[i]) > LVL_FLOOR) begin
              live_prio[i] = live_prio[i] - 1;
            end
          end
          live_prio[best] = base_prio[best];
          ticks_left = grant_len;
          running_slot = SLOT_W'(best);
          task_running = 1'b1;
        end
      end
      OP_TICK: begin
        if (task_running) begin
          if (ticks_left != 0) begin
            ticks_left = ticks_left - 1;
          end else begin
            r.preempt = 1'b1;
            task_running = 1'b0;
          end
        end
      end
      OP_YIELD: begin
        task_running = 1'b0;
      end
      default: begin
      end
    endcase
    r.chosen = running_slot;
    r.qleft = ticks_left;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stall, and every accepted beat checked against the
  // oldest expectation
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input int exp_v, input int act_v,
                             input logic [OP_W-1:0] op);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch (opcode %0d): expected %0d, actual %0d",
               $time, name, op, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, actual status %0d slot %0d",
                 $time, out_status, out_chosen_slot);
        fail_count++;
      end else begin
        oldest = expected_results.pop_front();
        check_field("status", oldest.status, out_status, oldest.op);
        check_field("chosen_slot", oldest.chosen, out_chosen_slot, oldest.op);
        check_field("preempt", oldest.preempt, out_preempt, oldest.op);
        check_field("quantum_left", oldest.qleft, out_quantum_left, oldest.op);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  // Presents one command beat, holds it until taken, then books its result.
  // in_valid is left high on purpose; the next call or a drain decides.
  task automatic send_cmd(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                          input logic [LEVEL_W-1:0] raw_prio);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_slot         <= slot;
    in_priority_req <= raw_prio;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(predict_sched_step(op, slot, raw_prio));
  endtask

  // lowers valid and waits until every booked result has been seen
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // one APB transfer: setup, access, complete on pready
  task automatic apb_access(input bit is_write, input logic [APB_ADDR_W-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (is_write && addr == QLEN_ADDR) grant_len = wdata[QNT_W-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_quantum(input logic [QNT_W-1:0] qlen);
    logic [31:0] unused_rd;
    apb_access(1'b1, QLEN_ADDR, 32'(qlen), unused_rd);
  endtask

  // random legal priority most of the time, any 6-bit code otherwise
  function automatic logic [LEVEL_W-1:0] rand_level();
    if ($urandom_range(99) < 85) return LEVEL_W'($urandom_range(0, 40) - 20);
    return LEVEL_W'($urandom_range(0, 63));
  endfunction

  // a slot that is (or is not) occupied in the shadow, random if none fits
  function automatic logic [SLOT_W-1:0] pick_slot(input bit want_used);
    int cands[$];
    for (int i = 0; i < NUM_TASKS; i++) begin
      if (slot_used[i] == want_used) cands.push_back(i);
    end
    if (cands.size() == 0) return SLOT_W'($urandom_range(NUM_TASKS - 1));
    return SLOT_W'(cands[$urandom_range(cands.size() - 1)]);
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // register comes up at its reset length and reads back what was written
  task automatic test_register_access();
    logic [31:0] rd;
    apb_access(1'b0, QLEN_ADDR, '0, rd);
    check_field("quantum_length reset", QLEN_RESET, rd[QNT_W-1:0], OP_YIELD);
    apb_access(1'b1, QLEN_ADDR, 32'h0000_00A5, rd);
    apb_access(1'b0, QLEN_ADDR, '0, rd);
    check_field("quantum_length readback", 8'hA5, rd[QNT_W-1:0], OP_YIELD);
    set_quantum(QLEN_RESET);
  endtask

  // every opcode, saturation, tie break, bad slot states, empty table
  task automatic test_directed_ops();
    send_cmd(OP_TICK, 4'd0, '0);          // nothing running
    send_cmd(OP_YIELD, 4'd0, '0);
    send_cmd(OP_SCHEDULE, 4'd0, '0);      // empty table
    send_cmd(OP_SET_PRIO, 4'd5, 6'd3);    // empty slot
    send_cmd(OP_REMOVE, 4'd5, '0);        // empty slot
    send_cmd(OP_RSVD_A, 4'd9, 6'h3F);
    send_cmd(OP_RSVD_B, 4'd15, 6'h2A);
    send_cmd(OP_ADD, 4'd0, 6'h1F);        // +31 clamps to +20
    send_cmd(OP_ADD, 4'd15, 6'h20);       // -32 clamps to -20
    send_cmd(OP_ADD, 4'd3, LEVEL_W'(-20));
    send_cmd(OP_ADD, 4'd7, LEVEL_W'(20));
    send_cmd(OP_ADD, 4'd0, 6'd1);         // occupied
    send_cmd(OP_SET_PRIO, 4'd7, LEVEL_W'(-21));
    send_cmd(OP_SCHEDULE, 4'd0, '0);      // three-way tie at the floor
    send_cmd(OP_TICK, 4'd0, '0);
    send_cmd(OP_SCHEDULE, 4'd0, '0);
    send_cmd(OP_SET_PRIO, 4'd3, 6'd10);
    send_cmd(OP_SCHEDULE, 4'd0, '0);
    send_cmd(OP_REMOVE, 4'd7, '0);        // may be the running one
    send_cmd(OP_TICK, 4'd0, '0);
    send_cmd(OP_SCHEDULE, 4'd0, '0);
    send_cmd(OP_YIELD, 4'd0, '0);
    for (int i = 0; i < NUM_TASKS; i++) begin
      if (slot_used[i]) send_cmd(OP_REMOVE, SLOT_W'(i), '0);
    end
    send_cmd(OP_SCHEDULE, 4'd0, '0);      // empty again
    drain_results();
  endtask

  // zero, one and full quantum: the exhausting tick preempts
  task automatic test_quantum_extremes();
    set_quantum(8'd0);
    send_cmd(OP_ADD, 4'd9, 6'd0);
    send_cmd(OP_SCHEDULE, 4'd0, '0);
    send_cmd(OP_TICK, 4'd0, '0);
    send_cmd(OP_TICK, 4'd0, '0);
    drain_results();
    set_quantum(8'd1);
    send_cmd(OP_SCHEDULE, 4'd0, '0);
    repeat (3) send_cmd(OP_TICK, 4'd0, '0);
    drain_results();
    set_quantum(8'd255);
    send_cmd(OP_SCHEDULE, 4'd0, '0);
    repeat (257) send_cmd(OP_TICK, 4'd0, '0);
    send_cmd(OP_REMOVE, 4'd9, '0);
    drain_results();
  endtask

  // Mostly well-formed traffic against the shadow's view of the table, with
  // some commands aimed at the wrong slot state and some unused opcodes.
  task automatic run_random_phase(input int send_pct, input int recv_pct,
                                  input logic [QNT_W-1:0] qlen, input int n_items);
    int sent;
    int pick;
    int burst;
    drain_results();
    set_quantum(qlen);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 24) begin
        send_cmd(OP_ADD, ($urandom_range(99) < 80) ? pick_slot(1'b0)
                                                   : SLOT_W'($urandom_range(15)),
                 rand_level());
        sent++;
      end else if (pick < 34) begin
        send_cmd(OP_SET_PRIO, ($urandom_range(99) < 80) ? pick_slot(1'b1)
                                                        : SLOT_W'($urandom_range(15)),
                 rand_level());
        sent++;
      end else if (pick < 46) begin
        send_cmd(OP_REMOVE, ($urandom_range(99) < 80) ? pick_slot(1'b1)
                                                      : SLOT_W'($urandom_range(15)),
                 LEVEL_W'($urandom_range(63)));
        sent++;
      end else if (pick < 62) begin
        send_cmd(OP_SCHEDULE, SLOT_W'($urandom_range(15)), LEVEL_W'($urandom_range(63)));
        sent++;
      end else if (pick < 68) begin
        // dispatch then run the quantum down, often past its end
        burst = $urandom_range(1, ((qlen > 20) ? 20 : int'(qlen)) + 2);
        send_cmd(OP_SCHEDULE, SLOT_W'($urandom_range(15)), rand_level());
        repeat (burst) send_cmd(OP_TICK, SLOT_W'($urandom_range(15)), rand_level());
        sent += burst + 1;
      end else if (pick < 88) begin
        send_cmd(OP_TICK, SLOT_W'($urandom_range(15)), LEVEL_W'($urandom_range(63)));
        sent++;
      end else if (pick < 95) begin
        send_cmd(OP_YIELD, SLOT_W'($urandom_range(15)), LEVEL_W'($urandom_range(63)));
        sent++;
      end else begin
        send_cmd($urandom_range(1) ? OP_RSVD_A : OP_RSVD_B,
                 SLOT_W'($urandom_range(15)), LEVEL_W'($urandom_range(63)));
        sent++;
      end
    end
  endtask

  // three idle profiles, each with its own quantum length
  task automatic test_random_traffic();
    run_random_phase(17, 63, 8'd5, 700);
    run_random_phase(63, 17, 8'd255, 700);
    run_random_phase(0, 0, 8'd1, 600);
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // sequence: single reset, tests in turn, settle, verdict
  // ---------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 17;
    recv_idle_pct = 63;
    test_register_access();
    test_directed_ops();
    test_quantum_extremes();
    test_random_traffic();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
